### hw/rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions for the JSON string
// unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Decoder modes, one-hot
  typedef enum logic [6:0] {
    ModeNormal  = 7'b0000001,
    ModeEsc     = 7'b0000010,
    ModeHex1    = 7'b0000100,
    ModeWantBsl = 7'b0001000,
    ModeWantU   = 7'b0010000,
    ModeHex2    = 7'b0100000,
    ModeSwallow = 7'b1000000
  } mode_e;

  // Error codes
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrBadEsc    = 3'd1;
  localparam logic [2:0] ErrBadHex    = 3'd2;
  localparam logic [2:0] ErrNoLowSurr = 3'd3;
  localparam logic [2:0] ErrTrunc     = 3'd4;

  // Character codes
  localparam logic [7:0] ChBsl   = 8'h5C;  // backslash
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;

  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [7:0] CtlTab = 8'h09;

  localparam logic [5:0]  HighSurrTag = 6'b110110;   // D800..DBFF
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [20:0] CpMax       = 21'h10FFFF;

  // Encoded code point: up to four bytes, count 1..4
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

  // One queue record: the result beats caused by one input beat
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      n_m1;      // number of beats minus one
    logic            has_data;  // 0: single empty end-of-string beat
    logic            last;      // input beat closed the string
    logic [2:0]      err;       // error code, nonzero only when last
  } rec_t;

  // Queue status toward the front and back ends
  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic enc_t utf8_encode(logic [20:0] cp_in);
    enc_t       r;
    logic [20:0] cp;
    r  = '0;
    cp = (cp_in > CpMax) ? CpMax : cp_in;
    if (cp <= 21'h7F) begin
      r.bytes[0] = cp[7:0];
      r.cnt      = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one input beat per cycle while the queue has room,
// tracks escape state and pushes one record per beat with bytes or string end.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire q_stat_t    q_stat_i,
  output logic            push_o,
  output rec_t            push_rec_o
);

  mode_e       mode_q, mode_d;
  logic [1:0]  digits_q, digits_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hs_q, hs_d;
  logic [2:0]  err_q, err_d;

  logic        accept;
  logic [4:0]  hv;
  logic [15:0] acc_new;
  enc_t        enc;
  logic [2:0]  err_out;

  assign in_ready_o = q_stat_i.not_full;
  assign accept     = in_valid_i && in_ready_o;
  assign hv         = hex_value(in_byte_i);
  assign acc_new    = {acc_q[11:0], hv[3:0]};

  always_comb begin
    mode_d   = mode_q;
    digits_d = digits_q;
    acc_d    = acc_q;
    hs_d     = hs_q;
    err_d    = err_q;
    enc      = '0;
    err_out  = ErrNone;

    unique case (mode_q) inside
      ModeNormal: begin
        if (in_byte_i == ChBsl) begin
          mode_d = ModeEsc;
        end else begin
          enc.bytes[0] = in_byte_i;
          enc.cnt      = 3'd1;
        end
      end
      ModeEsc: begin
        mode_d  = ModeNormal;
        enc.cnt = 3'd1;
        unique case (in_byte_i) inside
          ChQuote, ChSlash, ChBsl: enc.bytes[0] = in_byte_i;
          ChB: enc.bytes[0] = CtlBs;
          ChF: enc.bytes[0] = CtlFf;
          ChN: enc.bytes[0] = CtlLf;
          ChR: enc.bytes[0] = CtlCr;
          ChT: enc.bytes[0] = CtlTab;
          ChU: begin
            enc.cnt  = 3'd0;
            mode_d   = ModeHex1;
            digits_d = 2'd0;
            acc_d    = '0;
          end
          default: begin
            enc.cnt = 3'd0;
            err_d   = ErrBadEsc;
            mode_d  = ModeSwallow;
          end
        endcase
      end
      ModeHex1, ModeHex2: begin
        if (!hv[4]) begin
          err_d  = ErrBadHex;
          mode_d = ModeSwallow;
        end else begin
          acc_d = acc_new;
          if (digits_q != 2'd3) begin
            digits_d = digits_q + 2'd1;
          end else begin
            digits_d = 2'd0;
            if (mode_q == ModeHex2) begin
              enc    = utf8_encode(SuppBase + {1'b0, hs_q, acc_new[9:0]});
              mode_d = ModeNormal;
            end else if (acc_new[15:10] == HighSurrTag) begin
              hs_d   = acc_new[9:0];
              mode_d = ModeWantBsl;
            end else begin
              enc    = utf8_encode({5'd0, acc_new});
              mode_d = ModeNormal;
            end
          end
        end
      end
      ModeWantBsl: begin
        if (in_byte_i == ChBsl) begin
          mode_d = ModeWantU;
        end else begin
          err_d  = ErrNoLowSurr;
          mode_d = ModeSwallow;
        end
      end
      ModeWantU: begin
        if (in_byte_i == ChU) begin
          mode_d   = ModeHex2;
          digits_d = 2'd0;
          acc_d    = '0;
        end else begin
          err_d  = ErrNoLowSurr;
          mode_d = ModeSwallow;
        end
      end
      ModeSwallow: begin
      end
      default: begin
        mode_d = ModeNormal;
      end
    endcase

    // end of string: report and return to reset state
    if (in_last_i) begin
      err_out = err_d;
      if (mode_d != ModeNormal && mode_d != ModeSwallow && err_d == ErrNone) begin
        err_out = ErrTrunc;
      end
      mode_d   = ModeNormal;
      digits_d = '0;
      acc_d    = '0;
      hs_d     = '0;
      err_d    = ErrNone;
    end
  end

  assign push_o              = accept && (enc.cnt != 3'd0 || in_last_i);
  assign push_rec_o.bytes    = enc.bytes;
  assign push_rec_o.n_m1     = (enc.cnt == 3'd0) ? 2'd0 : 2'(enc.cnt - 3'd1);
  assign push_rec_o.has_data = (enc.cnt != 3'd0);
  assign push_rec_o.last     = in_last_i;
  assign push_rec_o.err      = err_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeNormal;
      digits_q <= '0;
      acc_q    <= '0;
      hs_q     <= '0;
      err_q    <= ErrNone;
    end else if (accept) begin
      mode_q   <= mode_d;
      digits_q <= digits_d;
      acc_q    <= acc_d;
      hs_q     <= hs_d;
      err_q    <= err_d;
    end
  end

  // sticky error only lives while swallowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ErrNone) |-> (mode_q == ModeSwallow))
    else $error("jsu_front: error recorded outside swallow mode");

endmodule

`default_nettype wire

### hw/rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of decoded records between the decoder and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned Depth = 4   // power of two, 2 or more
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rec_t push_rec_i,
  input  wire logic pop_i,
  output rec_t      head_o,
  output q_stat_t   stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.not_full  = (count_q != CntW'(Depth));
  assign stat_o.not_empty = (count_q != '0);
  assign head_o           = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("jsu_queue: count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> stat_o.not_full)
    else $error("jsu_queue: push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> stat_o.not_empty)
    else $error("jsu_queue: pop while empty");

endmodule

`default_nettype wire

### hw/rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: holds one record in the output register and sends its bytes
// one beat per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire rec_t    head_i,
  input  wire q_stat_t q_stat_i,
  output logic         pop_o,
  output logic [7:0]   out_byte_o,
  output logic         byte_valid_o,
  output logic         run_last_o,
  output logic         string_end_o,
  output logic [2:0]   error_code_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i
);

  rec_t       cur_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       fire, final_beat;

  assign fire       = valid_q && out_ready_i;
  assign final_beat = (idx_q == cur_q.n_m1);
  assign pop_o      = q_stat_i.not_empty && (!valid_q || (fire && final_beat));

  assign out_valid_o  = valid_q;
  assign out_byte_o   = cur_q.has_data ? cur_q.bytes[idx_q] : 8'h00;
  assign byte_valid_o = cur_q.has_data;
  assign run_last_o   = final_beat;
  assign string_end_o = final_beat && cur_q.last;
  assign error_code_o = string_end_o ? cur_q.err : ErrNone;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire) begin
      if (final_beat) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= cur_q.n_m1))
    else $error("jsu_back: beat index beyond record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !cur_q.has_data) |-> (cur_q.last && cur_q.n_m1 == 2'd0))
    else $error("jsu_back: empty record that does not end a string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && error_code_o != ErrNone) |-> string_end_o)
    else $error("jsu_back: error code on a non-final beat");

endmodule

`default_nettype wire

### hw/rtl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper: expands backslash escapes and \uXXXX
// sequences (with surrogate pairs) into UTF-8 bytes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_byte_i, in_last_i
//  out     | output    | out_valid_o / out_ready_i| out_byte_o, byte_valid_o,
//          |           |                          | run_last_o, string_end_o,
//          |           |                          | error_code_o
//
//  - Decoder takes one input beat per cycle while the record queue has room;
//    state update and UTF-8 encoding happen in that same cycle.
//  - Each input beat turns into at most one queue record of 1..4 result
//    beats; the serializer sends one beat per cycle while out_ready_i is
//    high, one beat per result byte. Sustained input rate is one beat per
//    cycle as long as the output keeps up on average.
//  - Queue is QueueDepth records deep; when it fills, in_ready_o drops.
//  - rst_ni is asynchronous, active low; it clears the decoder state, the
//    queue pointers and the output register's valid flag. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input beat
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  // output beat
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            run_last_o,
  output logic            string_end_o,
  output logic [2:0]      error_code_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i
);

  q_stat_t q_stat;
  logic    push, pop;
  rec_t    push_rec, head_rec;

  // Front: escape state machine and UTF-8 encoder
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  // Record queue decouples decode from byte-by-byte output
  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head_rec),
    .stat_o     (q_stat)
  );

  // Back: output register and beat serializer
  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_rec),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .error_code_o (error_code_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  // end of string is always the last beat of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && string_end_o) |-> run_last_o)
    else $error("top: string end without run last");

  // accepted input never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> q_stat.not_full)
    else $error("top: input accepted with queue full");

endmodule

`default_nettype wire

### sim/tb_json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top
// Self-checking bench for the JSON string unescaper. Strings built from
// escape tokens (plain bytes, short escapes, \uXXXX, surrogate pairs and
// broken forms) go in under random valid/ready idling. A scoreboard predicts
// the UTF-8 result beats and checks every output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_top;
  import jsu_pkg::*;

  localparam int unsigned ItemTarget  = 370;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongHold    = 80;   // receiver hold-off, in cycles
  localparam int unsigned TailCycles  = 20;   // settle time after last result

  // One predicted result beat
  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic       run_last;
    logic       str_end;
    logic [2:0] err;
  } utf8_beat_t;

  // Token kinds used to build random string bodies
  typedef enum int {
    TokPlain,
    TokShortEsc,
    TokBmp,
    TokPair,
    TokLowOrNull,
    TokBadEsc,
    TokBadHex,
    TokBrokenPair,
    TokCut
  } tok_e;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks decoder state, queues the expected UTF-8 beats for
  // each accepted input beat and compares output beats in order.
  // --------------------------------------------------------------------------
  class unescape_scoreboard;
    mode_e       mode;
    logic [1:0]  digits;
    logic [15:0] acc;
    logic [9:0]  high_bits;
    logic [2:0]  err_held;
    logic [7:0]  emitted[$];
    utf8_beat_t  pending_beats[$];
    int unsigned mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      mode      = ModeNormal;
      digits    = '0;
      acc       = '0;
      high_bits = '0;
      err_held  = ErrNone;
    endfunction

    function int unsigned outstanding();
      return pending_beats.size();
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void flag_error(logic [2:0] code);
      err_held = code;
      mode     = ModeSwallow;
    endfunction

    function void emit_code_point(logic [20:0] cp_raw);
      logic [20:0] cp;
      cp = (cp_raw > CpMax) ? CpMax : cp_raw;
      if (cp < 21'h80) begin
        emitted.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
        emitted.push_back(8'hC0 | 8'(cp >> 6));
        emitted.push_back(8'h80 | 8'(cp & 21'h3F));
      end else if (cp < 21'h10000) begin
        emitted.push_back(8'hE0 | 8'(cp >> 12));
        emitted.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
        emitted.push_back(8'h80 | 8'(cp & 21'h3F));
      end else begin
        emitted.push_back(8'hF0 | 8'(cp >> 18));
        emitted.push_back(8'h80 | 8'((cp >> 12) & 21'h3F));
        emitted.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
        emitted.push_back(8'h80 | 8'(cp & 21'h3F));
      end
    endfunction

    // Called once per accepted input beat
    function void absorb_byte(logic [7:0] b, logic is_last);
      int         nib;
      logic [2:0] final_err;
      utf8_beat_t beat;
      logic       fin;
      emitted   = {};
      final_err = ErrNone;
      case (mode) inside
        ModeNormal: begin
          if (b == ChBsl) mode = ModeEsc;
          else emitted.push_back(b);
        end
        ModeEsc: begin
          mode = ModeNormal;
          case (b) inside
            ChQuote, ChSlash, ChBsl: emitted.push_back(b);
            ChB: emitted.push_back(CtlBs);
            ChF: emitted.push_back(CtlFf);
            ChN: emitted.push_back(CtlLf);
            ChR: emitted.push_back(CtlCr);
            ChT: emitted.push_back(CtlTab);
            ChU: begin
              mode   = ModeHex1;
              digits = '0;
              acc    = '0;
            end
            default: flag_error(ErrBadEsc);
          endcase
        end
        ModeHex1, ModeHex2: begin
          nib = nibble_of(b);
          if (nib < 0) begin
            flag_error(ErrBadHex);
          end else begin
            acc = {acc[11:0], 4'(nib)};
            if (digits != 2'd3) begin
              digits = digits + 2'd1;
            end else begin
              digits = '0;
              if (mode == ModeHex1) begin
                if (acc[15:10] == HighSurrTag) begin
                  high_bits = acc[9:0];
                  mode      = ModeWantBsl;
                end else begin
                  emit_code_point({5'd0, acc});
                  mode = ModeNormal;
                end
              end else begin
                // second escape: only its low ten bits count
                emit_code_point(SuppBase + 21'({high_bits, acc[9:0]}));
                mode = ModeNormal;
              end
            end
          end
        end
        ModeWantBsl: begin
          if (b == ChBsl) mode = ModeWantU;
          else flag_error(ErrNoLowSurr);
        end
        ModeWantU: begin
          if (b == ChU) begin
            mode   = ModeHex2;
            digits = '0;
            acc    = '0;
          end else begin
            flag_error(ErrNoLowSurr);
          end
        end
        default: ;
      endcase

      if (is_last) begin
        if (mode != ModeNormal && mode != ModeSwallow && err_held == ErrNone)
          err_held = ErrTrunc;
        final_err = err_held;
        clear_state();
        if (emitted.size() == 0) begin
          beat = '{data: 8'h00, data_ok: 1'b0, run_last: 1'b1, str_end: 1'b1,
                   err: final_err};
          pending_beats.push_back(beat);
          return;
        end
      end

      foreach (emitted[k]) begin
        fin  = (k == emitted.size() - 1);
        beat = '{data: emitted[k], data_ok: 1'b1, run_last: fin,
                 str_end: fin && is_last,
                 err: (fin && is_last) ? final_err : ErrNone};
        pending_beats.push_back(beat);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Called once per accepted output beat
    function void check_beat(logic [7:0] data, logic data_ok, logic run_last,
                             logic str_end, logic [2:0] err);
      utf8_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: out_byte %0h byte_valid %0b", data, data_ok);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      compare_field("out_byte", want.data, data);
      compare_field("byte_valid", 8'(want.data_ok), 8'(data_ok));
      compare_field("run_last", 8'(want.run_last), 8'(run_last));
      compare_field("string_end", 8'(want.str_end), 8'(str_end));
      compare_field("error_code", 8'(want.err), 8'(err));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic       clk_i;
  logic       rst_ni;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       string_end_o;
  logic [2:0] error_code_o;
  logic       out_valid_o;
  logic       out_ready_i;

  json_string_unescape_utf8_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .error_code_o (error_code_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  unescape_scoreboard sb = new();

  logic [7:0]  text_bytes[$];      // string body being built
  logic [7:0]  short_esc[8] = '{ChQuote, ChSlash, ChBsl, ChB, ChF, ChN, ChR, ChT};
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          calm;               // no random idling on either side while set
  bit          long_hold_req;      // asks the receiver for one long hold-off

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All inputs known from time zero; reset released at a negedge
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = '0;
    in_last_i   = 1'b0;
    out_ready_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Monitor: input beats are noted before output beats of the same edge, so
  // a same-cycle result would still find its expectation.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.absorb_byte(in_byte_i, in_last_i);
      if (out_valid_o && out_ready_i)
        sb.check_beat(out_byte_o, byte_valid_o, run_last_o, string_end_o,
                      error_code_o);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("tb_json_string_unescape_utf8_top: FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    if (calm) return 0;
    return $urandom_range(9, 0);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls per beat, plus one long hold-off on request so
  // the record queue fills up and in_ready_o drops.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Valid stays up across back-to-back beats; dropped only for a gap or a drain.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_string();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // Sender pause: stop offering and wait for every expected beat
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    foreach (short_esc[i]) if (c == short_esc[i]) return 1'b1;
    return c == ChU;
  endfunction

  // Hex digit with random letter case
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1, 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_uescape(ref logic [7:0] q[$], input logic [15:0] v);
    q.push_back(ChBsl);
    q.push_back(ChU);
    for (int i = 3; i >= 0; i--) q.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic logic [15:0] pick_high();
    return 16'($urandom_range('hDBFF, 'hD800));
  endfunction

  function automatic logic [15:0] pick_low();
    return 16'($urandom_range('hDFFF, 'hDC00));
  endfunction

  function automatic tok_e pick_token();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 30) return TokPlain;
    if (r < 45) return TokShortEsc;
    if (r < 60) return TokBmp;
    if (r < 75) return TokPair;
    if (r < 80) return TokLowOrNull;
    if (r < 85) return TokBadEsc;
    if (r < 90) return TokBadHex;
    if (r < 95) return TokBrokenPair;
    return TokCut;
  endfunction

  // Random string body: mostly well-formed tokens with random content; error
  // tokens leave the rest of the string to be swallowed.
  task automatic build_string();
    int unsigned ntok;
    logic [7:0]  c;
    logic [15:0] v;
    logic [7:0]  seq[$];
    int unsigned n;
    text_bytes = {};
    ntok = $urandom_range(8, 1);
    for (int t = 0; t < ntok; t++) begin
      case (pick_token())
        TokPlain: begin
          do c = 8'($urandom_range(255, 0)); while (c == ChBsl);
          text_bytes.push_back(c);
        end
        TokShortEsc: begin
          text_bytes.push_back(ChBsl);
          text_bytes.push_back(short_esc[$urandom_range(7, 0)]);
        end
        TokBmp: begin
          case ($urandom_range(2, 0))
            0: v = 16'($urandom_range('h7F, 0));
            1: v = 16'($urandom_range('h7FF, 'h80));
            default: do v = 16'($urandom_range('hFFFF, 'h800));
                     while (v[15:10] == HighSurrTag);
          endcase
          add_uescape(text_bytes, v);
        end
        TokPair: begin
          add_uescape(text_bytes, pick_high());
          // mostly a true low surrogate, sometimes any value
          if ($urandom_range(9, 0) != 0) add_uescape(text_bytes, pick_low());
          else add_uescape(text_bytes, 16'($urandom_range('hFFFF, 0)));
        end
        TokLowOrNull: begin
          add_uescape(text_bytes, $urandom_range(1, 0) ? pick_low() : 16'h0000);
        end
        TokBadEsc: begin
          do c = 8'($urandom_range(255, 0)); while (is_escape_char(c));
          text_bytes.push_back(ChBsl);
          text_bytes.push_back(c);
        end
        TokBadHex: begin
          // bad digit in a plain escape or in the second half of a pair
          if ($urandom_range(1, 0)) begin
            add_uescape(text_bytes, pick_high());
          end
          text_bytes.push_back(ChBsl);
          text_bytes.push_back(ChU);
          n = $urandom_range(3, 0);
          repeat (n) text_bytes.push_back(hex_char(4'($urandom_range(15, 0))));
          do c = 8'($urandom_range(255, 0)); while (is_hex_char(c));
          text_bytes.push_back(c);
        end
        TokBrokenPair: begin
          add_uescape(text_bytes, pick_high());
          if ($urandom_range(1, 0)) begin
            do c = 8'($urandom_range(255, 0)); while (c == ChBsl);
          end else begin
            text_bytes.push_back(ChBsl);
            do c = 8'($urandom_range(255, 0)); while (c == ChU);
          end
          text_bytes.push_back(c);
        end
        default: begin
          // string ends partway into a surrogate pair escape
          seq = {};
          add_uescape(seq, pick_high());
          add_uescape(seq, pick_low());
          n = $urandom_range(11, 1);
          for (int i = 0; i < n; i++) text_bytes.push_back(seq[i]);
          return;
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit mid_drained;
    items_sent    = 0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    mid_drained   = 1'b0;
    @(posedge rst_ni);

    // Byte extremes and every short escape, ending on a tab escape
    text_bytes = {8'h00, 8'hFF, ChBsl, ChQuote, ChBsl, ChSlash, ChBsl, ChBsl,
                  ChBsl, ChB, ChBsl, ChF, ChBsl, ChN, ChBsl, ChR, ChBsl, ChT};
    send_string();
    // Unknown escape, then a swallowed byte closing the string
    text_bytes = {ChBsl, 8'h71, 8'h41};
    send_string();
    // String cut right after \u, and one cut after a lone backslash
    text_bytes = {ChBsl, ChU};
    send_string();
    text_bytes = {ChBsl};
    send_string();
    drain_results();

    // Long receiver hold-off while the sender keeps offering back to back
    calm          = 1'b1;
    long_hold_req = 1'b1;
    while (items_sent < 50) begin
      build_string();
      send_string();
    end
    calm = 1'b0;

    while (items_sent < ItemTarget) begin
      calm = ($urandom_range(5, 0) == 0);
      build_string();
      send_string();
      if (!mid_drained && items_sent >= ItemTarget / 2) begin
        drain_results();
        mid_drained = 1'b1;
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_json_string_unescape_utf8_top: PASS");
    end else begin
      $display("tb_json_string_unescape_utf8_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8_top.sv
sim/tb_json_string_unescape_utf8_top.sv
